FILE: sv/tsf_pkg.sv
// shared types, constants and register indices for the turn signal flasher
package tsf_pkg;

  localparam int TimerBitsDefault = 16;

  localparam int DebounceMsWidth = 14;
  localparam int BlinkMsWidth    = 14;
  localparam int TickMsWidth     = 10;
  localparam int CfgDataWidth    = 14;
  localparam int CfgIndexWidth   = 2;

  localparam logic [DebounceMsWidth-1:0] DebounceMsReset = 14'd30;
  localparam logic [BlinkMsWidth-1:0]    BlinkMsReset    = 14'd100;
  localparam logic [TickMsWidth-1:0]     TickMsReset     = 10'd10;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_DEBOUNCE_MS = 2'd0,
    CFG_BLINK_MS    = 2'd1,
    CFG_TICK_MS     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    BTN_UP      = 2'd0,
    BTN_FALLING = 2'd1,
    BTN_DOWN    = 2'd2,
    BTN_RISING  = 2'd3
  } btn_phase_t;

  typedef struct packed {
    logic left_level;
    logic right_level;
  } in_item_t;

  typedef struct packed {
    logic left_lamp;
    logic right_lamp;
    logic left_on;
    logic right_on;
  } out_item_t;

endpackage

FILE: sv/tsf_debounce.sv
// four-phase button debouncer with saturating hold timer
module tsf_debounce #(
  parameter int TIMER_BITS = tsf_pkg::TimerBitsDefault
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  logic                                  level,
  input  logic [tsf_pkg::DebounceMsWidth-1:0]   debounce_ms,
  input  logic [tsf_pkg::TickMsWidth-1:0]       tick_ms,
  output logic                                  release_event
);

  localparam int CmpW = (TIMER_BITS > tsf_pkg::DebounceMsWidth) ?
                        TIMER_BITS : tsf_pkg::DebounceMsWidth;
  localparam int SumW = ((TIMER_BITS > tsf_pkg::TickMsWidth) ?
                        TIMER_BITS : tsf_pkg::TickMsWidth) + 1;
  localparam logic [SumW-1:0] TimerMax = SumW'({TIMER_BITS{1'b1}});

  tsf_pkg::btn_phase_t phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic                  held;
  logic [SumW-1:0]       sum;
  logic [TIMER_BITS-1:0] timer_inc;

  assign held      = CmpW'(timer_r) >= CmpW'(debounce_ms);
  assign sum       = SumW'(timer_r) + SumW'(tick_ms);
  assign timer_inc = (sum > TimerMax) ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      tsf_pkg::BTN_UP: begin
        if (level) phase_nxt = tsf_pkg::BTN_FALLING;
      end
      tsf_pkg::BTN_FALLING: begin
        if (held) phase_nxt = level ? tsf_pkg::BTN_DOWN : tsf_pkg::BTN_UP;
      end
      tsf_pkg::BTN_DOWN: begin
        if (!level) phase_nxt = tsf_pkg::BTN_RISING;
      end
      tsf_pkg::BTN_RISING: begin
        if (held) phase_nxt = level ? tsf_pkg::BTN_DOWN : tsf_pkg::BTN_UP;
      end
      default: phase_nxt = tsf_pkg::BTN_UP;
    endcase
  end

  // timer and event
  always_comb begin
    timer_nxt     = timer_r;
    release_event = 1'b0;
    unique case (phase_r)
      tsf_pkg::BTN_UP: begin
        if (level) timer_nxt = '0;
      end
      tsf_pkg::BTN_FALLING: begin
        timer_nxt = timer_inc;
      end
      tsf_pkg::BTN_DOWN: begin
        if (!level) timer_nxt = '0;
      end
      tsf_pkg::BTN_RISING: begin
        timer_nxt     = timer_inc;
        release_event = step && held && !level;
      end
      default: timer_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tsf_pkg::BTN_UP;
      timer_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

FILE: sv/turn_signal_flasher_unit.sv
// turn signal flasher top level: debouncers, blinker state and result register
// Each tick item carries the two raw button levels and yields one result holding
// the lamp drives and the active flags after that tick. The whole update of both
// debouncers, the active flags and the shared blink timer is one combinational
// pass from the stored state, so an item is taken on every clock cycle in which
// in_stall is low, and its result appears in the output register on the next
// cycle; a new item is still taken while that result is pending if the output
// side takes it in the same cycle. in_stall follows out_stall only while a result
// is waiting. Write the three registers only while the block is idle.
module turn_signal_flasher_unit #(
  parameter int TIMER_BITS = tsf_pkg::TimerBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tsf_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tsf_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [tsf_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [tsf_pkg::CfgDataWidth-1:0]    cfg_wdata
);

  localparam int CmpW = (TIMER_BITS > tsf_pkg::BlinkMsWidth) ?
                        TIMER_BITS : tsf_pkg::BlinkMsWidth;
  localparam int SumW = ((TIMER_BITS > tsf_pkg::TickMsWidth) ?
                        TIMER_BITS : tsf_pkg::TickMsWidth) + 1;
  localparam logic [SumW-1:0] TimerMax = SumW'({TIMER_BITS{1'b1}});

  logic [tsf_pkg::DebounceMsWidth-1:0] debounce_ms_r;
  logic [tsf_pkg::BlinkMsWidth-1:0]    blink_ms_r;
  logic [tsf_pkg::TickMsWidth-1:0]     tick_ms_r;

  logic                  left_active_r, left_active_nxt;
  logic                  right_active_r, right_active_nxt;
  logic                  left_blink_phase_r, left_blink_phase_nxt;
  logic                  right_blink_phase_r, right_blink_phase_nxt;
  logic                  left_lamp_r, left_lamp_nxt;
  logic                  right_lamp_r, right_lamp_nxt;
  logic [TIMER_BITS-1:0] blink_timer_r, blink_timer_nxt;
  logic                  out_valid_r;
  tsf_pkg::out_item_t    out_data_r;

  logic                  in_xfer;
  logic                  left_event, right_event;
  logic                  left_mid, right_mid;
  logic                  blink_due;
  logic [TIMER_BITS-1:0] blink_base;
  logic [SumW-1:0]       blink_sum;

  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= tsf_pkg::DebounceMsReset;
      blink_ms_r    <= tsf_pkg::BlinkMsReset;
      tick_ms_r     <= tsf_pkg::TickMsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        tsf_pkg::CFG_DEBOUNCE_MS: debounce_ms_r <= cfg_wdata[tsf_pkg::DebounceMsWidth-1:0];
        tsf_pkg::CFG_BLINK_MS:    blink_ms_r    <= cfg_wdata[tsf_pkg::BlinkMsWidth-1:0];
        tsf_pkg::CFG_TICK_MS:     tick_ms_r     <= cfg_wdata[tsf_pkg::TickMsWidth-1:0];
        default: ;
      endcase
    end
  end

  tsf_debounce #(.TIMER_BITS(TIMER_BITS)) u_left_btn (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_xfer),
    .level         (in_data.left_level),
    .debounce_ms   (debounce_ms_r),
    .tick_ms       (tick_ms_r),
    .release_event (left_event)
  );

  tsf_debounce #(.TIMER_BITS(TIMER_BITS)) u_right_btn (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_xfer),
    .level         (in_data.right_level),
    .debounce_ms   (debounce_ms_r),
    .tick_ms       (tick_ms_r),
    .release_event (right_event)
  );

  assign blink_due = CmpW'(blink_timer_r) >= CmpW'(blink_ms_r);

  // active flags, left event handled first
  always_comb begin
    left_mid         = left_event ? !left_active_r : left_active_r;
    right_mid        = (left_event && !left_active_r) ? 1'b0 : right_active_r;
    right_active_nxt = right_event ? !right_mid : right_mid;
    left_active_nxt  = (right_event && !right_mid) ? 1'b0 : left_mid;
  end

  // blinker
  always_comb begin
    left_blink_phase_nxt  = left_blink_phase_r;
    right_blink_phase_nxt = right_blink_phase_r;
    left_lamp_nxt         = left_lamp_r;
    right_lamp_nxt        = right_lamp_r;
    blink_base            = blink_timer_r;
    if (left_active_nxt) begin
      if (blink_due) begin
        left_blink_phase_nxt = !left_blink_phase_r;
        left_lamp_nxt        = !left_blink_phase_r;
        blink_base           = '0;
      end
    end else if (right_active_nxt) begin
      if (blink_due) begin
        right_blink_phase_nxt = !right_blink_phase_r;
        right_lamp_nxt        = !right_blink_phase_r;
        blink_base            = '0;
      end
    end else begin
      left_lamp_nxt  = 1'b0;
      right_lamp_nxt = 1'b0;
      blink_base     = '0;
    end
    blink_sum       = SumW'(blink_base) + SumW'(tick_ms_r);
    blink_timer_nxt = (blink_sum > TimerMax) ? {TIMER_BITS{1'b1}} :
                      blink_sum[TIMER_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_active_r       <= 1'b0;
      right_active_r      <= 1'b0;
      left_blink_phase_r  <= 1'b0;
      right_blink_phase_r <= 1'b0;
      left_lamp_r         <= 1'b0;
      right_lamp_r        <= 1'b0;
      blink_timer_r       <= '0;
    end else if (in_xfer) begin
      left_active_r       <= left_active_nxt;
      right_active_r      <= right_active_nxt;
      left_blink_phase_r  <= left_blink_phase_nxt;
      right_blink_phase_r <= right_blink_phase_nxt;
      left_lamp_r         <= left_lamp_nxt;
      right_lamp_r        <= right_lamp_nxt;
      blink_timer_r       <= blink_timer_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r.left_lamp  <= left_lamp_nxt;
      out_data_r.right_lamp <= right_lamp_nxt;
      out_data_r.left_on    <= left_active_nxt;
      out_data_r.right_on   <= right_active_nxt;
    end
  end

  a_one_side_active: assert property (@(posedge clk) disable iff (!rst_n)
    !(left_active_r && right_active_r))
    else $error("both blinkers active");

  a_idle_lamps_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.left_on && !out_data_r.right_on |->
      !out_data_r.left_lamp && !out_data_r.right_lamp)
    else $error("lamp lit with no blinker active");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r && out_data_r.left_on == left_active_r &&
      out_data_r.right_on == right_active_r)
    else $error("result missing or out of step with state");

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !left_active_nxt && !right_active_nxt && blink_timer_r != '0 |=>
      blink_timer_r <= TIMER_BITS'(tick_ms_r) || &blink_timer_r)
    else $error("blink timer not cleared while idle");

endmodule

FILE: tb/turn_signal_flasher_unit_test.sv
`timescale 1ns / 1ps
// testbench for the turn signal flasher: directed and random ticks checked against a local model
module turn_signal_flasher_unit_test;

  localparam int TimerBits = tsf_pkg::TimerBitsDefault;
  localparam int CfgDataW = tsf_pkg::CfgDataWidth;
  localparam logic [tsf_pkg::CfgIndexWidth-1:0] CfgIndexUnused = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int ReportLimit = 10;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tsf_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  tsf_pkg::out_item_t out_data;
  logic cfg_we;
  logic [tsf_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [tsf_pkg::CfgDataWidth-1:0] cfg_wdata;

  turn_signal_flasher_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [tsf_pkg::DebounceMsWidth-1:0] debounce_cfg = tsf_pkg::DebounceMsReset;
  logic [tsf_pkg::BlinkMsWidth-1:0] blink_cfg = tsf_pkg::BlinkMsReset;
  logic [tsf_pkg::TickMsWidth-1:0] tick_cfg = tsf_pkg::TickMsReset;
  tsf_pkg::btn_phase_t btn_phase [2] = '{tsf_pkg::BTN_UP, tsf_pkg::BTN_UP};
  logic [TimerBits-1:0] btn_timer [2] = '{'0, '0};
  logic [TimerBits-1:0] blink_timer = '0;
  logic left_act = 1'b0;
  logic right_act = 1'b0;
  logic left_phase = 1'b0;
  logic right_phase = 1'b0;
  logic left_lamp = 1'b0;
  logic right_lamp = 1'b0;

  tsf_pkg::out_item_t pending_lamps [$];
  int mismatches = 0;
  int transfers = 0;
  int cycle_count = 0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;

  function automatic logic [TimerBits-1:0] timer_add(input logic [TimerBits-1:0] t);
    logic [TimerBits:0] sum;
    sum = {1'b0, t} + (TimerBits + 1)'(tick_cfg);
    return sum[TimerBits] ? {TimerBits{1'b1}} : sum[TimerBits-1:0];
  endfunction

  function automatic tsf_pkg::out_item_t flasher_next(input tsf_pkg::in_item_t item);
    logic lv [2];
    logic released [2];
    tsf_pkg::out_item_t r;
    int s;
    lv[0] = item.left_level;
    lv[1] = item.right_level;
    for (s = 0; s < 2; s++) begin
      released[s] = 1'b0;
      case (btn_phase[s])
        tsf_pkg::BTN_UP: begin
          if (lv[s]) begin
            btn_phase[s] = tsf_pkg::BTN_FALLING;
            btn_timer[s] = '0;
          end
        end
        tsf_pkg::BTN_FALLING: begin
          if (btn_timer[s] >= TimerBits'(debounce_cfg))
            btn_phase[s] = lv[s] ? tsf_pkg::BTN_DOWN : tsf_pkg::BTN_UP;
          btn_timer[s] = timer_add(btn_timer[s]);
        end
        tsf_pkg::BTN_DOWN: begin
          if (!lv[s]) begin
            btn_phase[s] = tsf_pkg::BTN_RISING;
            btn_timer[s] = '0;
          end
        end
        default: begin
          if (btn_timer[s] >= TimerBits'(debounce_cfg)) begin
            if (!lv[s]) begin
              btn_phase[s] = tsf_pkg::BTN_UP;
              released[s] = 1'b1;
            end else begin
              btn_phase[s] = tsf_pkg::BTN_DOWN;
            end
          end
          btn_timer[s] = timer_add(btn_timer[s]);
        end
      endcase
    end
    if (released[0]) begin
      left_act = !left_act;
      if (left_act) right_act = 1'b0;
    end
    if (released[1]) begin
      right_act = !right_act;
      if (right_act) left_act = 1'b0;
    end
    if (left_act) begin
      if (blink_timer >= TimerBits'(blink_cfg)) begin
        left_phase = !left_phase;
        left_lamp = left_phase;
        blink_timer = '0;
      end
    end else if (right_act) begin
      if (blink_timer >= TimerBits'(blink_cfg)) begin
        right_phase = !right_phase;
        right_lamp = right_phase;
        blink_timer = '0;
      end
    end else begin
      left_lamp = 1'b0;
      right_lamp = 1'b0;
      blink_timer = '0;
    end
    blink_timer = timer_add(blink_timer);
    r.left_lamp = left_lamp;
    r.right_lamp = right_lamp;
    r.left_on = left_act;
    r.right_on = right_act;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver side: random stalls, quiet stretches and one long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin : check_results
    tsf_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      transfers++;
      if (pending_lamps.size() == 0) begin
        if (mismatches < ReportLimit)
          $display("transfer %0d: result %b with nothing pending", transfers, out_data);
        mismatches++;
      end else begin
        want = pending_lamps.pop_front();
        if (out_data.left_lamp !== want.left_lamp || out_data.right_lamp !== want.right_lamp ||
            out_data.left_on !== want.left_on || out_data.right_on !== want.right_on) begin
          if (mismatches < ReportLimit)
            $display("transfer %0d: expected lamps/on %b, got %b", transfers, want, out_data);
          mismatches++;
        end
      end
    end
  end

  task automatic send_tick(input logic left_lv, input logic right_lv);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{left_level: left_lv, right_level: right_lv};
    do @(posedge clk); while (in_stall);
    pending_lamps.push_back(flasher_next(in_data));
  endtask

  task automatic send_levels(input logic left_lv, input logic right_lv, input int count);
    repeat (count) send_tick(left_lv, right_lv);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_lamps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [tsf_pkg::CfgIndexWidth-1:0] idx,
                           input logic [tsf_pkg::CfgDataWidth-1:0] value);
    settle_block();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      tsf_pkg::CFG_DEBOUNCE_MS: debounce_cfg = value[tsf_pkg::DebounceMsWidth-1:0];
      tsf_pkg::CFG_BLINK_MS:    blink_cfg = value[tsf_pkg::BlinkMsWidth-1:0];
      tsf_pkg::CFG_TICK_MS:     tick_cfg = value[tsf_pkg::TickMsWidth-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [tsf_pkg::CfgDataWidth-1:0] debounce_val,
                               input logic [tsf_pkg::CfgDataWidth-1:0] blink_val,
                               input logic [tsf_pkg::CfgDataWidth-1:0] tick_val);
    cfg_write(tsf_pkg::CFG_DEBOUNCE_MS, debounce_val);
    cfg_write(tsf_pkg::CFG_BLINK_MS, blink_val);
    cfg_write(tsf_pkg::CFG_TICK_MS, tick_val);
  endtask

  // button presses with hold times around the debounce threshold, some too short
  task automatic run_random_ticks(input int count);
    logic lv [2];
    int run_left [2];
    int thr;
    int n;
    int s;
    thr = (tick_cfg == 0) ? 3 : int'(debounce_cfg) / int'(tick_cfg) + 1;
    if (thr > 48) thr = 48;
    lv[0] = 1'b0;
    lv[1] = 1'b0;
    run_left[0] = $urandom_range(0, 3);
    run_left[1] = $urandom_range(0, 3);
    for (n = 0; n < count; n++) begin
      for (s = 0; s < 2; s++) begin
        if (run_left[s] == 0) begin
          lv[s] = !lv[s];
          run_left[s] = ($urandom_range(99) < 80) ? thr + $urandom_range(0, 3)
                                                   : $urandom_range(1, thr);
          if (!lv[s] && $urandom_range(99) < 30) run_left[s] += $urandom_range(0, 40);
        end
        run_left[s]--;
      end
      send_tick(lv[0], lv[1]);
    end
  endtask

  task automatic test_reset_values();
    send_levels(1'b1, 1'b0, 5);
    send_levels(1'b0, 1'b0, 5);
    send_levels(1'b0, 1'b1, 2);
  endtask

  task automatic test_register_extremes();
    // tick write carries upper bits that the register drops
    set_registers('0, '0, 14'h3C01);
    send_levels(1'b1, 1'b1, 2);
    send_levels(1'b0, 1'b0, 2);
    send_levels(1'b1, 1'b0, 2);
    send_levels(1'b0, 1'b0, 2);
    send_levels(1'b0, 1'b0, 1);
    set_registers('1, '1, '0);
    cfg_write(CfgIndexUnused, '1);
    send_levels(1'b0, 1'b1, 3);
    send_levels(1'b0, 1'b0, 2);
  endtask

  task automatic test_config_sweep();
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_registers('0, '0, 14'd1);
        1: set_registers('1, '1, 14'd1023);
        2: set_registers(tsf_pkg::DebounceMsReset, tsf_pkg::BlinkMsReset,
                         CfgDataW'(tsf_pkg::TickMsReset));
        3: set_registers('0, '0, '0);
        default: set_registers(CfgDataW'($urandom_range(0, 40)),
                               CfgDataW'($urandom_range(0, 120)),
                               CfgDataW'($urandom_range(1, 20)));
      endcase
      if (phase == 1) cfg_write(CfgIndexUnused, '0);
      run_random_ticks(185);
    end
  endtask

  task automatic test_quiet_stretch();
    quiet <= 1'b1;
    run_random_ticks(200);
    quiet <= 1'b0;
  endtask

  task automatic test_backpressure();
    set_registers(14'd20, 14'd30, 14'd10);
    hold_req <= !hold_req;
    run_random_ticks(250);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_register_extremes();
    test_config_sweep();
    test_quiet_stretch();
    test_backpressure();
    settle_block();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_lamps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tsf_pkg.sv
sv/tsf_debounce.sv
sv/turn_signal_flasher_unit.sv
tb/turn_signal_flasher_unit_test.sv
